### rtl/idrf_pkg.sv
// Shared constants, types and helpers for the idle-dedup receive FIFO.
package idrf_pkg;

    // Ring depth; the pointers wrap naturally, so this must be a power of two.
    localparam int FIFO_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(FIFO_DEPTH);

    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 10;

    // Input side: tdata = {first_of_packet, data_byte}, padded to bytes.
    localparam int IN_W       = BYTE_W + 1;
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] FILL_BYTE  = 8'hFF;
    localparam logic [BYTE_W-1:0] IDLE_HI    = 8'h80;
    localparam logic [BYTE_W-1:0] IDLE_LO    = 8'h10;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_POP_WAIT
    } state_t;

    // One result item, last field in the lowest bits.
    typedef struct packed {
        logic [COUNT_W-1:0] available_count;
        logic [COUNT_W-1:0] fill_count;
        logic               overflow;
        logic               byte_stored;
        logic               pop_valid;
        logic [BYTE_W-1:0]  popped_byte;
    } result_t;

    localparam int OUT_W       = $bits(result_t);
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    function automatic logic is_idle(input logic [BYTE_W-1:0] v);
        return (v >= IDLE_HI) || (v < IDLE_LO);
    endfunction

endpackage

### rtl/idrf_ram.sv
// Generic single-clock RAM, one write port, one read port, registered read.
module idrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/idle_dedup_rx_fifo.sv
// Top level of the receive byte FIFO with idle-byte suppression.
//
//  channel  dir  payload                                     handshake
//  -------  ---  ------------------------------------------  ---------------------------
//  s_axis   in   tuser: mode; tdata: data_byte, first_of_pkt  s_axis_tvalid/s_axis_tready
//  m_axis   out  tdata: result_t (popped byte, flags, counts)  m_axis_tvalid/m_axis_tready
//
//  A push and a pop of an empty FIFO are answered straight from ST_IDLE; a pop
//  that returns a byte also passes through ST_POP_WAIT, since the new head entry
//  comes from the registered RAM read port.
//  Reset clears the pointers, the previous-byte tracker and the FSM; the byte
//  RAM is not cleared, only occupied entries are ever used.
//  Results sit in an output register; a new item is taken while the FSM is idle
//  and that register is empty or is being drained in the same cycle.
module idle_dedup_rx_fifo
    import idrf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte, [8] first_of_packet
    input  logic                   s_axis_tuser,   // [0] mode (0 push, 1 pop)

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [7:0] popped_byte, [8] pop_valid,
                                                   // [9] byte_stored, [10] overflow,
                                                   // [20:11] fill_count,
                                                   // [30:21] available_count
);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [BYTE_W-1:0] prev_reg,   prev_next;
    // Copy of the oldest unread byte; meaningful only while the FIFO is non-empty.
    logic [BYTE_W-1:0] head_reg,   head_next;
    logic [BYTE_W-1:0] popped_reg, popped_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg,  out_data_next;

    logic              accept;
    logic              mode;
    logic [BYTE_W-1:0] data_byte;
    logic              first_of_packet;

    logic              empty;
    logic              full;
    logic [ADDR_W-1:0] fill_cur;
    logic [ADDR_W-1:0] fill_new;
    logic [ADDR_W-1:0] wr_inc;
    logic [ADDR_W-1:0] rd_inc;
    logic [BYTE_W-1:0] prev_eff;
    logic [BYTE_W-1:0] head_new;
    logic              drop;
    logic              store;

    logic              ram_we;
    logic [BYTE_W-1:0] ram_rdata;

    assign mode            = s_axis_tuser;
    assign data_byte       = s_axis_tdata[BYTE_W-1:0];
    assign first_of_packet = s_axis_tdata[BYTE_W];

    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign empty    = (wr_ptr_reg == rd_ptr_reg);
    assign wr_inc   = wr_ptr_reg + 1'b1;
    assign rd_inc   = rd_ptr_reg + 1'b1;
    assign full     = (wr_inc == rd_ptr_reg);
    assign fill_cur = wr_ptr_reg - rd_ptr_reg;

    // Push filter: a new packet restarts dedup from the head byte (or 0 if empty).
    assign prev_eff = first_of_packet ? (empty ? '0 : head_reg) : prev_reg;
    assign drop     = (is_idle(data_byte) && (data_byte == prev_eff)) ||
                      (data_byte == FILL_BYTE);
    assign store    = !drop && !full;
    assign head_new = empty ? data_byte : head_reg;
    assign fill_new = fill_cur + ADDR_W'(store);

    assign ram_we = accept && (mode == MODE_PUSH) && store;

    // Byte store. The read port always looks one past the head, so a pop
    // has the next head in the cycle after. Pushes and pops are separate items,
    // so the read that a pop uses never meets a write to the same entry.
    idrf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (data_byte),
        .raddr (rd_inc),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_POP) && !empty)
                begin
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result
    always_comb
    begin
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        prev_next      = prev_reg;
        head_next      = head_reg;
        popped_next    = popped_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_PUSH)
                    begin
                        prev_next = data_byte;
                        if (store)
                        begin
                            wr_ptr_next = wr_inc;
                            head_next   = head_new;
                        end
                        out_valid_next              = 1'b1;
                        out_data_next.popped_byte   = '0;
                        out_data_next.pop_valid     = 1'b0;
                        out_data_next.byte_stored   = store;
                        out_data_next.overflow      = !drop && full;
                        out_data_next.fill_count    = COUNT_W'(fill_new);
                        if (fill_new > ADDR_W'(1))
                        begin
                            out_data_next.available_count = COUNT_W'(fill_new);
                        end
                        else if ((fill_new == ADDR_W'(1)) && is_idle(head_new))
                        begin
                            out_data_next.available_count = COUNT_W'(1);
                        end
                        else
                        begin
                            out_data_next.available_count = '0;
                        end
                    end
                    else if (empty)
                    begin
                        // Pop of an empty FIFO: answered at once, nothing changes.
                        out_valid_next                = 1'b1;
                        out_data_next.popped_byte     = '0;
                        out_data_next.pop_valid       = 1'b0;
                        out_data_next.byte_stored     = 1'b0;
                        out_data_next.overflow        = 1'b0;
                        out_data_next.fill_count      = '0;
                        out_data_next.available_count = '0;
                    end
                    else
                    begin
                        popped_next = head_reg;
                        rd_ptr_next = rd_inc;
                    end
                end
            end
            ST_POP_WAIT:
            begin
                // RAM now presents the new head; pointers already advanced.
                head_next                     = ram_rdata;
                out_valid_next                = 1'b1;
                out_data_next.popped_byte     = popped_reg;
                out_data_next.pop_valid       = 1'b1;
                out_data_next.byte_stored     = 1'b0;
                out_data_next.overflow        = 1'b0;
                out_data_next.fill_count      = COUNT_W'(fill_cur);
                if (fill_cur > ADDR_W'(1))
                begin
                    out_data_next.available_count = COUNT_W'(fill_cur);
                end
                else if ((fill_cur == ADDR_W'(1)) && is_idle(ram_rdata))
                begin
                    out_data_next.available_count = COUNT_W'(1);
                end
                else
                begin
                    out_data_next.available_count = '0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        head_reg     <= head_next;
        popped_reg   <= popped_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_data_reg};

endmodule

### sim/tb_idle_dedup_rx_fifo.sv
// Self-checking testbench for the idle-dedup receive byte FIFO.
`timescale 1ns / 100ps

module tb_idle_dedup_rx_fifo;
    import idrf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] data_byte, [8] first_of_packet
    logic                   s_axis_tuser = 1'b0; // [0] mode

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // result_t, popped_byte in the low bits

    idle_dedup_rx_fifo dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the FIFO: ring, pointers and the last incoming byte.
    logic [BYTE_W-1:0] shadow_ring [FIFO_DEPTH];
    logic [ADDR_W-1:0] shadow_wr = '0;
    logic [ADDR_W-1:0] shadow_rd = '0;
    logic [BYTE_W-1:0] shadow_prev = '0;

    result_t expected_results [$];

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int rx_hold_left = 0;
    int failure_count = 0;

    int push_count = 0;
    int pop_count = 0;
    int stored_count = 0;
    int overflow_count = 0;
    int popped_count = 0;
    int hold_cycles_total = 0;

    function automatic logic rx_byte_idle(input logic [BYTE_W-1:0] b);
        return (b >= 8'h80) || (b < 8'h10);
    endfunction

    // Applies one accepted item to the shadow FIFO and returns its result.
    function automatic result_t predict_fifo_item(input logic mode,
                                                  input logic [BYTE_W-1:0] rx_byte,
                                                  input logic sop);
        result_t r;
        logic [ADDR_W-1:0] fill;
        r = '0;
        if (mode == MODE_PUSH)
        begin
            push_count++;
            // New packet: dedup restarts against the oldest unread byte
            if (sop)
                shadow_prev = (shadow_wr != shadow_rd) ? shadow_ring[shadow_rd] : 8'h00;
            if (rx_byte_idle(rx_byte) && rx_byte == shadow_prev)
                ; // repeated idle byte
            else if (rx_byte == 8'hFF)
                ; // fill byte
            else if (ADDR_W'(shadow_wr + 1'b1) == shadow_rd)
            begin
                r.overflow = 1'b1;
                overflow_count++;
            end
            else
            begin
                shadow_ring[shadow_wr] = rx_byte;
                shadow_wr = shadow_wr + 1'b1;
                r.byte_stored = 1'b1;
                stored_count++;
            end
            shadow_prev = rx_byte;   // tracked even when dropped
        end
        else
        begin
            pop_count++;
            if (shadow_wr != shadow_rd)
            begin
                r.popped_byte = shadow_ring[shadow_rd];
                r.pop_valid = 1'b1;
                shadow_rd = shadow_rd + 1'b1;
                popped_count++;
            end
        end
        fill = shadow_wr - shadow_rd;
        r.fill_count = COUNT_W'(fill);
        if (fill > 1)
            r.available_count = COUNT_W'(fill);
        else if (fill == 1 && rx_byte_idle(shadow_ring[shadow_rd]))
            r.available_count = COUNT_W'(1);
        else
            r.available_count = '0;
        return r;
    endfunction

    // Offers one item from a falling edge, returns at the falling edge after
    // it was taken. tvalid stays high so back-to-back items need no re-raise.
    task automatic send_item(input logic mode, input logic [BYTE_W-1:0] rx_byte,
                             input logic sop);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {{(IN_TDATA_W-IN_W){1'b0}}, sop, rx_byte};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(predict_fifo_item(mode, rx_byte, sop));
        @(negedge clk);
    endtask

    // Drops tvalid and waits until every expected result has come back.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (expected_results.size() != 0);
    endtask

    // Filter corners, packet restarts, pops at one byte held and when empty.
    task automatic test_directed();
        send_item(MODE_POP,  8'($urandom_range(255)), 1'b0);   // empty pop
        send_item(MODE_PUSH, 8'h00, 1'b1);   // idle, equals reset tracker
        send_item(MODE_PUSH, 8'hFF, 1'b0);   // fill byte
        send_item(MODE_PUSH, 8'h80, 1'b0);
        send_item(MODE_PUSH, 8'h80, 1'b0);   // repeated idle
        send_item(MODE_PUSH, 8'h41, 1'b0);
        send_item(MODE_PUSH, 8'h41, 1'b0);   // non-idle repeat is kept
        send_item(MODE_PUSH, 8'h0F, 1'b0);   // idle low edge
        send_item(MODE_PUSH, 8'h10, 1'b0);   // first non-idle
        send_item(MODE_PUSH, 8'h7F, 1'b0);   // last non-idle
        send_item(MODE_PUSH, 8'hFE, 1'b0);
        send_item(MODE_PUSH, 8'hFE, 1'b0);
        send_item(MODE_PUSH, 8'h80, 1'b1);   // restart: matches oldest unread
        send_item(MODE_PUSH, 8'h81, 1'b1);
        for (int i = 0; i < 7; i++)
            send_item(MODE_POP, 8'($urandom_range(255)), 1'($urandom_range(1)));
        send_item(MODE_POP,  8'h00, 1'b0);   // lone idle byte leaves
        send_item(MODE_PUSH, 8'h41, 1'b1);   // restart on empty FIFO
        send_item(MODE_POP,  8'hFF, 1'b1);
    endtask

    // Mostly packets of idle-heavy bytes followed by pops, some raw noise.
    task automatic test_random_traffic(input int n_items);
        int sent;
        int plen;
        int npop;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] last_b;
        sent = 0;
        last_b = 8'h80;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 80)
            begin
                plen = $urandom_range(1, 8);
                for (int i = 0; i < plen; i++)
                begin
                    case ($urandom_range(9))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        2:       b = 8'h80;
                        3:       b = 8'h0F;
                        4, 5:    b = last_b;
                        default: b = 8'($urandom_range(255));
                    endcase
                    send_item(MODE_PUSH, b, i == 0);
                    last_b = b;
                end
                npop = $urandom_range(0, plen + 1);
                for (int i = 0; i < npop; i++)
                    send_item(MODE_POP, 8'($urandom_range(255)), 1'($urandom_range(1)));
                sent += plen + npop;
            end
            else
            begin
                send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                          1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    // Receiver stalls for a long stretch while items keep coming in.
    task automatic test_receiver_hold_off();
        rx_hold_left = 150;
        hold_cycles_total += 150;
        for (int i = 0; i < 30; i++)
            send_item(1'(i % 3 == 2), 8'($urandom_range(255)), i % 7 == 0);
    endtask

    // Sender goes quiet until the output side has caught up.
    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++)
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)), i == 0);
        wait_for_drain();
        for (int i = 0; i < 20; i++)
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)), i == 0);
    endtask

    // Deep fill with distinct bytes and filter corners, then drain past empty.
    task automatic test_deep_fill();
        while (shadow_wr != shadow_rd)
            send_item(MODE_POP, 8'($urandom_range(255)), 1'b0);
        for (int i = 0; i < 96; i++)
            send_item(MODE_PUSH, 8'h10 + 8'(i % 112), i == 0);
        send_item(MODE_PUSH, 8'h90, 1'b0);   // idle, new value: stored
        send_item(MODE_PUSH, 8'h90, 1'b0);   // repeated idle: dropped
        send_item(MODE_PUSH, 8'hFF, 1'b0);
        send_item(MODE_PUSH, 8'h10, 1'b1);   // restart on a non-idle head
        for (int i = 0; i < 100; i++)
            send_item(MODE_POP, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // Receiver: random stalls, or a forced hold-off when one is pending.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[OUT_W-1:0]);
            if (expected_results.size() == 0)
            begin
                failure_count++;
                if (failure_count <= REPORT_LIMIT)
                    $display("ERROR: unexpected result %h at %0t", got, $realtime);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.popped_byte !== want.popped_byte || got.pop_valid !== want.pop_valid
                    || got.byte_stored !== want.byte_stored
                    || got.overflow !== want.overflow
                    || got.fill_count !== want.fill_count
                    || got.available_count !== want.available_count)
                begin
                    failure_count++;
                    if (failure_count <= REPORT_LIMIT)
                        $display({"ERROR at %0t: byte %h/%h valid %b/%b stored %b/%b ",
                                  "ovf %b/%b fill %0d/%0d avail %0d/%0d (exp/got)"},
                                 $realtime, want.popped_byte, got.popped_byte,
                                 want.pop_valid, got.pop_valid,
                                 want.byte_stored, got.byte_stored,
                                 want.overflow, got.overflow,
                                 want.fill_count, got.fill_count,
                                 want.available_count, got.available_count);
                end
            end
        end
    end

    // Watchdog: ends the run after too many cycles with no item moving.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_idle_pct = 26;
        rx_idle_pct = 81;
        test_directed();
        test_random_traffic(120);
        test_receiver_hold_off();

        tx_idle_pct = 81;
        rx_idle_pct = 26;
        test_random_traffic(120);
        test_drain_pause();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_deep_fill();
        test_random_traffic(100);

        wait_for_drain();
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            failure_count++;
            $display("ERROR: %0d results never arrived", expected_results.size());
        end

        $display("covered %0d pushes (%0d stored, %0d overflowed) and %0d pops (%0d with data)",
                 push_count, stored_count, overflow_count, pop_count, popped_count);
        $display("incl. a deep fill and drain, %0d-cycle output hold-off, %0d failures",
                 hold_cycles_total, failure_count);
        if (failure_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
